// ===== rtl/pidc_pkg.sv =====
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types and constants of the clamped-integrator PID step.
// ----------------------------------------------------------------------------
package pidc_pkg;

  // Time stamps and the sampling interval are plain 32-bit millisecond counts.
  localparam int TIME_WIDTH = 32;

  // Configuration register map.
  localparam int REG_INDEX_WIDTH = 3;

  typedef enum logic [REG_INDEX_WIDTH-1:0] {
    REG_SETPOINT   = 3'd0,
    REG_KP         = 3'd1,
    REG_KI_SCALED  = 3'd2,
    REG_KD_SCALED  = 3'd3,
    REG_RANGE_LOW  = 3'd4,
    REG_RANGE_HIGH = 3'd5,
    REG_INTERVAL   = 3'd6,
    REG_MODE       = 3'd7
  } pidc_reg_e;

  // Mode register bits.
  localparam int MODE_WIDTH   = 3;
  localparam int MODE_RUN     = 0;
  localparam int MODE_POI     = 1;
  localparam int MODE_REVERSE = 2;

  localparam logic [MODE_WIDTH-1:0] MODE_RESET     = 3'b010;
  localparam logic [TIME_WIDTH-1:0] INTERVAL_RESET = 32'd250;
  localparam logic [63:0]           RANGE_HIGH_RESET = 64'd6553600;

  // Product magnitude ceiling, 2^60 - 1.
  localparam int                PCAP_WIDTH = 60;
  localparam logic [PCAP_WIDTH-1:0] PCAP    = '1;

endpackage

// ===== rtl/pidc_sample_if.sv =====
// ----------------------------------------------------------------------------
// pidc_sample_if
// Input channel: one measured sample with its millisecond time stamp.
// ----------------------------------------------------------------------------
interface pidc_sample_if
  import pidc_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] sample;
  logic [TIME_WIDTH-1:0]         now_ms;

  modport source (output valid, sample, now_ms, input ready);
  modport sink   (input valid, sample, now_ms, output ready);
endinterface

// ===== rtl/pidc_result_if.sv =====
// ----------------------------------------------------------------------------
// pidc_result_if
// Output channel: drive value and the flag telling whether a step was taken.
// ----------------------------------------------------------------------------
interface pidc_result_if #(
  parameter int VALUE_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] control_output;
  logic                          updated;

  modport source (output valid, control_output, updated, input ready);
  modport sink   (input valid, control_output, updated, output ready);
endinterface

// ===== rtl/pidc_fxmul.sv =====
// ----------------------------------------------------------------------------
// pidc_fxmul
// Signed value times unsigned gain, shifted down with truncation toward zero,
// magnitude saturated, optionally negated.
// ----------------------------------------------------------------------------
module pidc_fxmul
  import pidc_pkg::*;
#(
  parameter int XW = 33,
  parameter int GW = 24,
  parameter int FW = 16,
  localparam int PW = XW + GW - FW,
  localparam int MW = (PW > PCAP_WIDTH) ? PCAP_WIDTH : PW,
  localparam int TW = MW + 1
) (
  input  logic signed [XW-1:0] x_i,
  input  logic [GW-1:0]        gain_i,
  input  logic                 flip_i,
  output logic signed [TW-1:0] term_o
);
  localparam int SW = (PW > PCAP_WIDTH) ? PW : PCAP_WIDTH + 1;

  logic [XW-1:0]      mag;
  logic [XW+GW-1:0]   prod;
  logic [SW-1:0]      ext;
  logic [MW-1:0]      capped;
  logic signed [TW-1:0] pos;
  logic               neg;

  always_comb begin
    mag    = x_i[XW-1] ? $unsigned(-x_i) : $unsigned(x_i);
    prod   = (XW + GW)'(mag) * (XW + GW)'(gain_i);
    ext    = SW'(prod[XW+GW-1:FW]);
    capped = (ext > SW'(PCAP)) ? MW'(PCAP) : MW'(ext);
    pos    = $signed({1'b0, capped});
    neg    = x_i[XW-1] ^ flip_i;
    term_o = neg ? -pos : pos;
  end
endmodule

// ===== rtl/pidc_clamp.sv =====
// ----------------------------------------------------------------------------
// pidc_clamp
// Limit a wide signed sum to [low,high]; inverted: high if above it, else low.
// ----------------------------------------------------------------------------
module pidc_clamp #(
  parameter int IW = 44,
  parameter int OW = 32
) (
  input  logic signed [IW-1:0] value_i,
  input  logic signed [OW-1:0] low_i,
  input  logic signed [OW-1:0] high_i,
  output logic signed [OW-1:0] value_o
);
  always_comb begin
    priority if (value_i > IW'(high_i)) begin
      value_o = high_i;
    end else if (value_i < IW'(low_i)) begin
      value_o = low_i;
    end else begin
      value_o = OW'(value_i);
    end
  end
endmodule

// ===== rtl/pid_step_with_clamped_integrator.sv =====
// ----------------------------------------------------------------------------
// pid_step_with_clamped_integrator
// Fixed-point PID step with anti-windup integrator and derivative on input.
// ----------------------------------------------------------------------------
// Path: the input register loads at the accepting edge, and one combinational
//   pass loads the result register once the result slot is free.
// Throughput: 1 item per cycle while out_if.ready holds; the state loop
//   closes within that pass.
// Reset: asynchronous, clears integrator, previous sample, schedule base and
//   held output; registers return to their documented defaults.
module pid_step_with_clamped_integrator
  import pidc_pkg::*;
#(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16,
  parameter int GAIN_WIDTH    = 24,
  localparam int CFG_WIDTH_VG = (VALUE_WIDTH > GAIN_WIDTH) ? VALUE_WIDTH : GAIN_WIDTH,
  localparam int CFG_WIDTH    = (CFG_WIDTH_VG > TIME_WIDTH) ? CFG_WIDTH_VG : TIME_WIDTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [REG_INDEX_WIDTH-1:0] cfg_index_i,
  input  logic [CFG_WIDTH-1:0]       cfg_wdata_i,
  pidc_sample_if.sink                in_if,
  pidc_result_if.source              out_if
);
  localparam int XW   = VALUE_WIDTH + 1;
  localparam int PW   = XW + GAIN_WIDTH - FRACTION_BITS;
  localparam int MW   = (PW > PCAP_WIDTH) ? PCAP_WIDTH : PW;
  localparam int TW   = MW + 1;
  localparam int SUMW = ((VALUE_WIDTH > TW) ? VALUE_WIDTH : TW) + 2;

  // Configuration registers
  logic signed [VALUE_WIDTH-1:0] setpoint_q, range_low_q, range_high_q;
  logic [GAIN_WIDTH-1:0]         kp_q, ki_q, kd_q;
  logic [TIME_WIDTH-1:0]         interval_q;
  logic [MODE_WIDTH-1:0]         mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q   <= '0;
      kp_q         <= '0;
      ki_q         <= '0;
      kd_q         <= '0;
      range_low_q  <= '0;
      range_high_q <= VALUE_WIDTH'(RANGE_HIGH_RESET);
      interval_q   <= INTERVAL_RESET;
      mode_q       <= MODE_RESET;
    end else if (cfg_we_i) begin
      unique case (pidc_reg_e'(cfg_index_i))
        REG_SETPOINT:   setpoint_q   <= VALUE_WIDTH'(cfg_wdata_i);
        REG_KP:         kp_q         <= GAIN_WIDTH'(cfg_wdata_i);
        REG_KI_SCALED:  ki_q         <= GAIN_WIDTH'(cfg_wdata_i);
        REG_KD_SCALED:  kd_q         <= GAIN_WIDTH'(cfg_wdata_i);
        REG_RANGE_LOW:  range_low_q  <= VALUE_WIDTH'(cfg_wdata_i);
        REG_RANGE_HIGH: range_high_q <= VALUE_WIDTH'(cfg_wdata_i);
        REG_INTERVAL:   interval_q   <= TIME_WIDTH'(cfg_wdata_i);
        REG_MODE:       mode_q       <= MODE_WIDTH'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // Input register
  logic                          in_valid_q;
  logic signed [VALUE_WIDTH-1:0] sample_q;
  logic [TIME_WIDTH-1:0]         now_q;

  // Result register
  logic                          out_valid_q;
  logic signed [VALUE_WIDTH-1:0] out_ctrl_q;
  logic                          out_upd_q;

  // Controller state
  logic signed [VALUE_WIDTH-1:0] integ_q, prev_q, held_q;
  logic [TIME_WIDTH-1:0]         base_q;

  logic fire;
  logic step;

  assign fire        = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      sample_q <= in_if.sample;
      now_q    <= in_if.now_ms;
    end
  end

  // Datapath
  logic signed [XW-1:0]          err, din, p_in;
  logic signed [TW-1:0]          p_term, i_term, d_term;
  logic signed [SUMW-1:0]        acc, y_sum;
  logic signed [VALUE_WIDTH-1:0] integ_d, y_clamped;
  logic                          poi, rev;
  logic [TIME_WIDTH-1:0]         elapsed;

  assign poi     = mode_q[MODE_POI];
  assign rev     = mode_q[MODE_REVERSE];
  assign elapsed = now_q - base_q;
  assign step    = mode_q[MODE_RUN] && (elapsed >= interval_q);

  assign err  = XW'(setpoint_q) - XW'(sample_q);
  assign din  = XW'(prev_q) - XW'(sample_q);
  // Kp sees the input change in proportional-on-input mode, the error otherwise
  assign p_in = poi ? din : err;

  pidc_fxmul #(.XW(XW), .GW(GAIN_WIDTH), .FW(FRACTION_BITS)) u_mul_p (
    .x_i(p_in), .gain_i(kp_q), .flip_i(rev), .term_o(p_term)
  );
  pidc_fxmul #(.XW(XW), .GW(GAIN_WIDTH), .FW(FRACTION_BITS)) u_mul_i (
    .x_i(err), .gain_i(ki_q), .flip_i(rev), .term_o(i_term)
  );
  pidc_fxmul #(.XW(XW), .GW(GAIN_WIDTH), .FW(FRACTION_BITS)) u_mul_d (
    .x_i(din), .gain_i(kd_q), .flip_i(rev), .term_o(d_term)
  );

  assign acc = SUMW'(integ_q) + (poi ? SUMW'(p_term) : SUMW'(0)) + SUMW'(i_term);

  pidc_clamp #(.IW(SUMW), .OW(VALUE_WIDTH)) u_clamp_integ (
    .value_i(acc), .low_i(range_low_q), .high_i(range_high_q), .value_o(integ_d)
  );

  assign y_sum = (poi ? SUMW'(0) : SUMW'(p_term)) + SUMW'(integ_d) + SUMW'(d_term);

  pidc_clamp #(.IW(SUMW), .OW(VALUE_WIDTH)) u_clamp_out (
    .value_i(y_sum), .low_i(range_low_q), .high_i(range_high_q), .value_o(y_clamped)
  );

  // Result register and state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      integ_q     <= '0;
      prev_q      <= '0;
      held_q      <= '0;
      base_q      <= '0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
      if (step) begin
        integ_q <= integ_d;
        prev_q  <= sample_q;
        held_q  <= y_clamped;
        base_q  <= base_q + interval_q;
      end
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_ctrl_q <= step ? y_clamped : held_q;
      out_upd_q  <= step;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.control_output = out_ctrl_q;
  assign out_if.updated        = out_upd_q;

  // Assertions
  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_if.ready)
    else $error("input stalled while result slot is free");

  a_fire_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed item produced no result");

  a_skip_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !step) |=> ($stable(integ_q) && $stable(prev_q) && $stable(base_q)
                         && $stable(held_q)))
    else $error("skipped step changed controller state");

  a_skip_shows_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_upd_q) |-> (out_ctrl_q == held_q))
    else $error("skipped result differs from held output");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives time-stamped samples into the clamped-integrator PID step and
// compares every drive value and step flag with a directed row's values or
// a cycle-free predictor keeping its own integrator, schedule and registers.
// ----------------------------------------------------------------------------
module tb_top;
  import pidc_pkg::*;

  localparam int VW            = 32;
  localparam int FRAC          = 16;
  localparam int GW            = 24;
  localparam int DIRECTED_ROWS = 34;
  localparam int PHASES        = 15;
  localparam int PHASE_ITEMS   = 96;

  localparam logic [31:0] M_RUN       = 32'd1 << MODE_RUN;
  localparam logic [31:0] M_POI       = 32'd1 << MODE_POI;
  localparam logic [31:0] M_REV       = 32'd1 << MODE_REVERSE;
  localparam logic [31:0] ONE_Q16     = 32'h0001_0000;
  localparam logic [31:0] TEN_Q16     = 32'h000A_0000;
  localparam logic [31:0] HUNDRED_Q16 = 32'h0064_0000;
  localparam logic [31:0] VALUE_MIN   = 32'h8000_0000;
  localparam logic [31:0] VALUE_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] GAIN_MAX    = 32'h00FF_FFFF;

  typedef struct packed {
    logic signed [VW-1:0] drive;
    logic                 updated;
  } pid_result_t;

  typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    pidc_reg_e   index;
    logic [31:0] value;
    logic [31:0] now;
    bit          known;
    logic [31:0] drive;
    logic        updated;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  pidc_reg_e   cfg_index;
  logic [31:0] cfg_wdata;

  pidc_sample_if #(.VALUE_WIDTH(VW)) smp_if ();
  pidc_result_if #(.VALUE_WIDTH(VW)) res_if ();

  pid_step_with_clamped_integrator #(
    .VALUE_WIDTH  (VW),
    .FRACTION_BITS(FRAC),
    .GAIN_WIDTH   (GW)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata),
    .in_if      (smp_if),
    .out_if     (res_if)
  );

  // Register copies, at their reset values.
  longint          cfg_setpoint = 0;
  longint          cfg_low      = 0;
  longint          cfg_high     = longint'(RANGE_HIGH_RESET);
  logic [GW-1:0]   cfg_kp       = '0;
  logic [GW-1:0]   cfg_ki       = '0;
  logic [GW-1:0]   cfg_kd       = '0;
  logic [31:0]     cfg_interval = INTERVAL_RESET;
  logic [MODE_WIDTH-1:0] cfg_mode = MODE_RESET;

  // Controller state.
  longint      st_integ = 0;
  longint      st_prev  = 0;
  longint      st_held  = 0;
  logic [31:0] st_base  = '0;

  pid_result_t pending_drive_q[$];
  pid_result_t want;
  stim_row_t   directed_rows[DIRECTED_ROWS];

  int src_idle_pct;
  int snk_stall_pct;
  int n_errors;
  int n_items;
  int n_steps;
  int n_writes;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("end of test: mismatches");
    $finish;
  end

  // (x * g) >> FRAC, truncated toward zero; reverse mode flips the sign.
  function automatic longint scaled_product(longint x, logic [GW-1:0] g, bit flip);
    longint mag;
    longint prod;
    bit     neg;
    neg  = (x < 0) != flip;
    mag  = (x < 0) ? -x : x;
    prod = (mag * longint'(g)) >>> FRAC;
    return neg ? -prod : prod;
  endfunction

  function automatic longint clamp_to_range(longint v);
    if (v > cfg_high) return cfg_high;
    if (v < cfg_low) return cfg_low;
    return v;
  endfunction

  function automatic pid_result_t pid_model_step(logic signed [VW-1:0] sample,
                                                 logic [31:0] now);
    logic [31:0] since;
    longint      err;
    longint      din;
    longint      acc;
    longint      drive;
    bit          flip;
    pid_result_t r;
    flip  = cfg_mode[MODE_REVERSE];
    since = now - st_base;
    if (!cfg_mode[MODE_RUN] || since < cfg_interval) begin
      r.drive   = st_held[VW-1:0];
      r.updated = 1'b0;
      return r;
    end
    st_base = st_base + cfg_interval;
    err     = cfg_setpoint - longint'(sample);
    din     = st_prev - longint'(sample);
    acc     = st_integ;
    drive   = 0;
    if (cfg_mode[MODE_POI]) begin
      acc += scaled_product(din, cfg_kp, flip);
    end else begin
      drive = scaled_product(err, cfg_kp, flip);
    end
    acc     += scaled_product(err, cfg_ki, flip);
    st_integ = clamp_to_range(acc);
    drive   += st_integ + scaled_product(din, cfg_kd, flip);
    st_held  = clamp_to_range(drive);
    st_prev  = longint'(sample);
    r.drive   = st_held[VW-1:0];
    r.updated = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t reg_row(pidc_reg_e idx, logic [31:0] value);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_WRITE;
    r.index = idx;
    r.value = value;
    return r;
  endfunction

  function automatic stim_row_t sample_row(logic [31:0] sample, logic [31:0] now);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_SAMPLE;
    r.value = sample;
    r.now   = now;
    return r;
  endfunction

  function automatic stim_row_t known_row(logic [31:0] sample, logic [31:0] now,
                                          logic [31:0] drive, logic updated);
    stim_row_t r;
    r         = sample_row(sample, now);
    r.known   = 1'b1;
    r.drive   = drive;
    r.updated = updated;
    return r;
  endfunction

  function automatic logic [31:0] pick_sample();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 10) return cfg_setpoint[31:0] + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    if (sel < 17) return $urandom;
    if (sel == 17) return VALUE_MIN;
    if (sel == 18) return VALUE_MAX;
    return st_prev[31:0];
  endfunction

  // Mostly due on schedule; some early, some arbitrary jumps in time.
  function automatic logic [31:0] pick_time();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 12) return st_base + cfg_interval + $urandom_range(0, 3);
    if (sel < 17) return st_base + $urandom_range(0, cfg_interval);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_gain();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return $urandom_range(0, 32'h0004_0000);
    if (sel < 8) return $urandom & GAIN_MAX;
    if (sel == 8) return '0;
    return GAIN_MAX;
  endfunction

  task automatic write_register(input pidc_reg_e idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      REG_SETPOINT:   cfg_setpoint = longint'($signed(value));
      REG_KP:         cfg_kp       = value[GW-1:0];
      REG_KI_SCALED:  cfg_ki       = value[GW-1:0];
      REG_KD_SCALED:  cfg_kd       = value[GW-1:0];
      REG_RANGE_LOW:  cfg_low      = longint'($signed(value));
      REG_RANGE_HIGH: cfg_high     = longint'($signed(value));
      REG_INTERVAL:   cfg_interval = value;
      REG_MODE:       cfg_mode     = value[MODE_WIDTH-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic send_item(input logic [31:0] sample, input logic [31:0] now,
                           input bit known, input pid_result_t known_res);
    pid_result_t res;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      smp_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    smp_if.valid  <= 1'b1;
    smp_if.sample <= sample;
    smp_if.now_ms <= now;
    do @(posedge clk_i); while (!smp_if.ready);
    res = pid_model_step(sample, now);
    pending_drive_q.push_back(known ? known_res : res);
    n_items++;
    if (res.updated) n_steps++;
  endtask

  // Hold the sender until every expected result has come back.
  task automatic settle_outputs();
    @(negedge clk_i);
    smp_if.valid <= 1'b0;
    while (pending_drive_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic randomize_settings();
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] swap;
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 12) write_register(REG_SETPOINT, $urandom_range(0, 100) << FRAC);
    else if (sel < 17) write_register(REG_SETPOINT, $urandom);
    else write_register(REG_SETPOINT, sel[0] ? VALUE_MIN : VALUE_MAX);
    write_register(REG_KP, pick_gain());
    write_register(REG_KI_SCALED, pick_gain());
    write_register(REG_KD_SCALED, pick_gain());
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      lo = -($urandom_range(0, 50) << FRAC);
      hi = $urandom_range(10, 200) << FRAC;
    end else if (sel < 7) begin
      lo = $urandom;
      hi = $urandom;
      if ($signed(lo) > $signed(hi)) begin
        swap = lo;
        lo   = hi;
        hi   = swap;
      end
    end else if (sel == 7) begin
      lo = VALUE_MIN;
      hi = VALUE_MAX;
    end else if (sel == 8) begin
      // inverted range
      lo = $urandom_range(1, 100) << FRAC;
      hi = -($urandom_range(0, 100) << FRAC);
    end else begin
      lo = $urandom;
      hi = lo;
    end
    write_register(REG_RANGE_LOW, lo);
    write_register(REG_RANGE_HIGH, hi);
    sel = $urandom_range(0, 19);
    if (sel < 12) write_register(REG_INTERVAL, $urandom_range(1, 20));
    else if (sel < 16) write_register(REG_INTERVAL, $urandom_range(21, 1000));
    else if (sel == 16) write_register(REG_INTERVAL, '0);
    else if (sel == 17) write_register(REG_INTERVAL, 32'hFFFF_FFFF);
    else write_register(REG_INTERVAL, $urandom);
    if ($urandom_range(0, 19) < 17) write_register(REG_MODE, $urandom_range(0, 7) | M_RUN);
    else write_register(REG_MODE, $urandom_range(0, 7));
  endtask

  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_drive_q.size() == 0) begin
        $error("result with nothing pending: control_output %0d, updated %0d",
               res_if.control_output, res_if.updated);
        n_errors++;
      end else begin
        want = pending_drive_q.pop_front();
        if (res_if.control_output !== want.drive) begin
          $error("control_output: expected %0d, got %0d", want.drive, res_if.control_output);
          n_errors++;
        end
        if (res_if.updated !== want.updated) begin
          $error("updated: expected %0d, got %0d", want.updated, res_if.updated);
          n_errors++;
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_SETPOINT;
    cfg_wdata     = '0;
    smp_if.valid  = 1'b0;
    smp_if.sample = '0;
    smp_if.now_ms = '0;
    src_idle_pct  = 38;
    snk_stall_pct = 77;
    n_errors      = 0;
    n_items       = 0;
    n_steps       = 0;
    n_writes      = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    directed_rows = '{
      // not running after reset: held zero
      known_row(32'h0, 32'd1000, 32'h0, 1'b0),
      known_row(VALUE_MAX, 32'hFFFF_FFFF, 32'h0, 1'b0),
      reg_row(REG_SETPOINT, TEN_Q16),
      reg_row(REG_KP, ONE_Q16),
      reg_row(REG_MODE, M_RUN),
      known_row(32'h0, 32'd250, TEN_Q16, 1'b1),
      known_row(32'h0, 32'd260, TEN_Q16, 1'b0),
      known_row(VALUE_MIN, 32'd500, HUNDRED_Q16, 1'b1),
      known_row(VALUE_MAX, 32'd750, 32'h0, 1'b1),
      reg_row(REG_KP, GAIN_MAX),
      reg_row(REG_KI_SCALED, GAIN_MAX),
      reg_row(REG_KD_SCALED, GAIN_MAX),
      reg_row(REG_RANGE_LOW, VALUE_MIN),
      reg_row(REG_RANGE_HIGH, VALUE_MAX),
      reg_row(REG_MODE, M_RUN | M_POI | M_REV),
      sample_row(VALUE_MIN, 32'd1000),
      sample_row(VALUE_MAX, 32'd1250),
      sample_row(32'h0, 32'd1250),
      // zero interval: every item steps, base stays put
      reg_row(REG_INTERVAL, 32'h0),
      sample_row(32'hFFFF_FFFF, 32'd0),
      sample_row(ONE_Q16, 32'd0),
      // widest interval: due only one tick before the base
      reg_row(REG_INTERVAL, 32'hFFFF_FFFF),
      sample_row(32'h1234_5678, 32'd1249),
      sample_row(32'h0, 32'd1249),
      reg_row(REG_MODE, M_RUN),
      // inverted range
      reg_row(REG_RANGE_LOW, HUNDRED_Q16),
      reg_row(REG_RANGE_HIGH, -HUNDRED_Q16),
      reg_row(REG_INTERVAL, 32'd1),
      sample_row(VALUE_MAX, 32'd1300),
      sample_row(VALUE_MIN, 32'd1301),
      sample_row(32'h0, 32'd1302),
      reg_row(REG_MODE, M_REV),
      sample_row(32'h5555_5555, 32'd5000),
      sample_row(32'hAAAA_AAAA, 32'd0)
    };

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        settle_outputs();
        write_register(directed_rows[i].index, directed_rows[i].value);
      end else begin
        send_item(directed_rows[i].value, directed_rows[i].now, directed_rows[i].known,
                  {directed_rows[i].drive, directed_rows[i].updated});
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle_outputs();
      if (p == PHASES / 3) begin
        src_idle_pct  = 77;
        snk_stall_pct = 38;
      end else if (p == 2 * PHASES / 3) begin
        src_idle_pct  = 0;
        snk_stall_pct = 0;
      end
      randomize_settings();
      repeat (PHASE_ITEMS) send_item(pick_sample(), pick_time(), 1'b0, '0);
    end

    settle_outputs();
    repeat (8) @(posedge clk_i);
    $display("covered %0d samples: %0d control steps, %0d held outputs", n_items, n_steps,
             n_items - n_steps);
    $display("across %0d register writes, %0d mismatches seen", n_writes, n_errors);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pidc_pkg.sv
rtl/pidc_sample_if.sv
rtl/pidc_result_if.sv
rtl/pidc_fxmul.sv
rtl/pidc_clamp.sv
rtl/pid_step_with_clamped_integrator.sv
test/tb_top.sv
